/* hw/rtl/ics_pkg.sv */
package ics_pkg;

    localparam int CAPACITY_DEFAULT = 16;

    localparam int STATUS_W = 3;
    localparam int COUNT_W  = 5;
    localparam int VALUE_W  = 64;

    localparam logic [STATUS_W-1:0] ST_ADDED    = 3'd0;
    localparam logic [STATUS_W-1:0] ST_MERGED   = 3'd1;
    localparam logic [STATUS_W-1:0] ST_SUBSUMED = 3'd2;
    localparam logic [STATUS_W-1:0] ST_FULL     = 3'd3;
    localparam logic [STATUS_W-1:0] ST_BADORDER = 3'd4;

endpackage

/* hw/rtl/ics_ram.sv */
module ics_ram #(
    parameter int WIDTH = 128,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

/* hw/rtl/interval_coalescing_set_core.sv */
// each input beat runs a compare pass over the slot ram, one slot per cycle through its read
// pipeline, then the finish state, which sets the result and writes the slot ram when the item
// is added or merged; a start after end skips the pass and goes straight to finish; a new item
// is taken only back in idle, after the last one is through
// the input stalls while an item is in work; a finished result may wait in the output register
// reset (rst_n low, asynchronous): the set is empty, no result is pending
module interval_coalescing_set_core #(
    parameter int CAPACITY = ics_pkg::CAPACITY_DEFAULT
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [ics_pkg::VALUE_W-1:0]  interval_start,
    input  logic [ics_pkg::VALUE_W-1:0]  interval_end,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [ics_pkg::STATUS_W-1:0] status,
    output logic [ics_pkg::VALUE_W-1:0]  stored_start,
    output logic [ics_pkg::VALUE_W-1:0]  stored_end,
    output logic [ics_pkg::COUNT_W-1:0]  absorbed_count,
    output logic [ics_pkg::COUNT_W-1:0]  entry_count
);

    localparam int IW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int VW = ics_pkg::VALUE_W;
    localparam logic [IW:0] CAP_IDX = (IW + 1)'(CAPACITY);
    localparam logic [CW-1:0] CAP_CNT = CW'(CAPACITY);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_SCAN   = 2'd1;
    localparam logic [1:0] S_FINISH = 2'd2;

    logic [1:0]          state_reg, state_next;
    logic [CAPACITY-1:0] slot_valid_reg, slot_valid_next;
    logic [CW-1:0]       total_reg, total_next;
    logic                out_valid_reg, out_valid_next;

    logic [IW:0]         iss_reg, iss_next;
    logic                ev_vld_reg, ev_vld_next;
    logic [IW-1:0]       ev_idx_reg, ev_idx_next;

    logic [VW-1:0]       s_reg, s_next;
    logic [VW-1:0]       e_reg, e_next;
    logic [VW-1:0]       lo_reg, lo_next;
    logic [VW-1:0]       hi_reg, hi_next;
    logic [VW-1:0]       sub_first_reg, sub_first_next;
    logic [VW-1:0]       sub_last_reg, sub_last_next;
    logic                bad_reg, bad_next;
    logic                found_reg, found_next;
    logic [CAPACITY-1:0] hit_reg, hit_next;
    logic [CW-1:0]       abs_reg, abs_next;
    logic [IW-1:0]       free_idx_reg, free_idx_next;
    logic                free_found_reg, free_found_next;

    logic [ics_pkg::STATUS_W-1:0] o_status_reg, o_status_next;
    logic [VW-1:0]                o_start_reg, o_start_next;
    logic [VW-1:0]                o_end_reg, o_end_next;
    logic [CW-1:0]                o_abs_reg, o_abs_next;
    logic [CW-1:0]                o_cnt_reg, o_cnt_next;

    logic                ram_we;
    logic [2*VW-1:0]     ram_rdata;
    logic [VW-1:0]       rd_first, rd_last;
    logic                slot_v, contain, overlap;
    logic                out_free;
    logic [31:0]         abs_wide, cnt_wide;

    ics_ram #(
        .WIDTH (2 * VW),
        .DEPTH (CAPACITY)
    ) u_slot_ram (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (free_idx_reg),
        .wr_data ({lo_reg, hi_reg}),
        .rd_addr (iss_reg[IW-1:0]),
        .rd_data (ram_rdata)
    );

    assign rd_first = ram_rdata[2*VW-1:VW];
    assign rd_last  = ram_rdata[VW-1:0];
    assign slot_v   = slot_valid_reg[ev_idx_reg];
    assign contain  = (rd_first <= s_reg) && (e_reg <= rd_last);
    assign overlap  = (s_reg <= rd_last) && (rd_first <= e_reg);
    assign out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        state_next      = state_reg;
        slot_valid_next = slot_valid_reg;
        total_next      = total_reg;
        out_valid_next  = out_valid_reg;
        iss_next        = iss_reg;
        ev_vld_next     = ev_vld_reg;
        ev_idx_next     = ev_idx_reg;
        s_next          = s_reg;
        e_next          = e_reg;
        lo_next         = lo_reg;
        hi_next         = hi_reg;
        sub_first_next  = sub_first_reg;
        sub_last_next   = sub_last_reg;
        bad_next        = bad_reg;
        found_next      = found_reg;
        hit_next        = hit_reg;
        abs_next        = abs_reg;
        free_idx_next   = free_idx_reg;
        free_found_next = free_found_reg;
        o_status_next   = o_status_reg;
        o_start_next    = o_start_reg;
        o_end_next      = o_end_reg;
        o_abs_next      = o_abs_reg;
        o_cnt_next      = o_cnt_reg;
        ram_we          = 1'b0;

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    s_next          = interval_start;
                    e_next          = interval_end;
                    lo_next         = interval_start;
                    hi_next         = interval_end;
                    bad_next        = interval_start > interval_end;
                    found_next      = 1'b0;
                    hit_next        = '0;
                    abs_next        = '0;
                    free_found_next = 1'b0;
                    free_idx_next   = '0;
                    iss_next        = '0;
                    ev_vld_next     = 1'b0;
                    state_next      = (interval_start > interval_end) ? S_FINISH : S_SCAN;
                end
            end
            S_SCAN:
            begin
                // read slot iss, evaluate the slot read on the previous cycle
                if (iss_reg != CAP_IDX)
                begin
                    ev_vld_next = 1'b1;
                    ev_idx_next = iss_reg[IW-1:0];
                    iss_next    = iss_reg + 1'b1;
                end
                else
                begin
                    ev_vld_next = 1'b0;
                    if (!ev_vld_reg)
                    begin
                        state_next = S_FINISH;
                    end
                end
                if (ev_vld_reg)
                begin
                    if (slot_v && contain)
                    begin
                        found_next     = 1'b1;
                        sub_first_next = rd_first;
                        sub_last_next  = rd_last;
                    end
                    if (slot_v && overlap)
                    begin
                        hit_next[ev_idx_reg] = 1'b1;
                        abs_next             = abs_reg + 1'b1;
                        if (rd_first < lo_reg)
                        begin
                            lo_next = rd_first;
                        end
                        if (rd_last > hi_reg)
                        begin
                            hi_next = rd_last;
                        end
                    end
                    // lowest slot that is free once the hits are cleared
                    if ((!slot_v || overlap) && !free_found_reg)
                    begin
                        free_found_next = 1'b1;
                        free_idx_next   = ev_idx_reg;
                    end
                end
            end
            S_FINISH:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    o_abs_next     = '0;
                    o_cnt_next     = total_reg;
                    o_start_next   = s_reg;
                    o_end_next     = e_reg;
                    priority if (bad_reg)
                    begin
                        o_status_next = ics_pkg::ST_BADORDER;
                    end
                    else if (found_reg)
                    begin
                        o_status_next = ics_pkg::ST_SUBSUMED;
                        o_start_next  = sub_first_reg;
                        o_end_next    = sub_last_reg;
                    end
                    else if (abs_reg == '0 && total_reg >= CAP_CNT)
                    begin
                        o_status_next = ics_pkg::ST_FULL;
                    end
                    else
                    begin
                        ram_we                        = 1'b1;
                        slot_valid_next               = slot_valid_reg & ~hit_reg;
                        slot_valid_next[free_idx_reg] = 1'b1;
                        total_next                    = total_reg - abs_reg + 1'b1;
                        o_status_next = (abs_reg != '0) ? ics_pkg::ST_MERGED
                                                        : ics_pkg::ST_ADDED;
                        o_start_next  = lo_reg;
                        o_end_next    = hi_reg;
                        o_abs_next    = abs_reg;
                        o_cnt_next    = total_reg - abs_reg + 1'b1;
                    end
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            slot_valid_reg <= '0;
            total_reg      <= '0;
            out_valid_reg  <= 1'b0;
            iss_reg        <= '0;
            ev_vld_reg     <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            slot_valid_reg <= slot_valid_next;
            total_reg      <= total_next;
            out_valid_reg  <= out_valid_next;
            iss_reg        <= iss_next;
            ev_vld_reg     <= ev_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ev_idx_reg     <= ev_idx_next;
        s_reg          <= s_next;
        e_reg          <= e_next;
        lo_reg         <= lo_next;
        hi_reg         <= hi_next;
        sub_first_reg  <= sub_first_next;
        sub_last_reg   <= sub_last_next;
        bad_reg        <= bad_next;
        found_reg      <= found_next;
        hit_reg        <= hit_next;
        abs_reg        <= abs_next;
        free_idx_reg   <= free_idx_next;
        free_found_reg <= free_found_next;
        o_status_reg   <= o_status_next;
        o_start_reg    <= o_start_next;
        o_end_reg      <= o_end_next;
        o_abs_reg      <= o_abs_next;
        o_cnt_reg      <= o_cnt_next;
    end

    // counts go out as their low bits
    assign abs_wide = 32'(o_abs_reg);
    assign cnt_wide = 32'(o_cnt_reg);

    assign in_stall       = (state_reg != S_IDLE);
    assign out_valid      = out_valid_reg;
    assign status         = o_status_reg;
    assign stored_start   = o_start_reg;
    assign stored_end     = o_end_reg;
    assign absorbed_count = abs_wide[ics_pkg::COUNT_W-1:0];
    assign entry_count    = cnt_wide[ics_pkg::COUNT_W-1:0];

endmodule
